### hw/rtl/text_glyph_planar_renderer_core_assert.svh
// Assertion macros shared by the glyph renderer RTL.
`ifndef TEXT_GLYPH_PLANAR_RENDERER_CORE_ASSERT_SVH
`define TEXT_GLYPH_PLANAR_RENDERER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TGPR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TGPR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

### hw/rtl/tgpr_pkg.sv
// Types, constants and codes of the planar text glyph renderer.
package tgpr_pkg;

	localparam int MAX_GLYPH_HEIGHT_DEF = 16;
	localparam int GLYPH_COUNT_DEF      = 256;
	localparam int GLYPH_WIDTH          = 8;
	localparam int BYTES_PER_ROW        = 80;
	localparam int SCREEN_LINES         = 480;
	localparam int PLANES               = 4;

	localparam int ACTION_W    = 2;
	localparam int CODE_W      = 8;
	localparam int COLOR_W     = PLANES;
	localparam int GLINE_W     = 4;
	localparam int MASK_W      = PLANES;
	localparam int ADDR_W      = 16;
	localparam int COL_W       = 7;
	localparam int ROW_W       = 6;
	localparam int HCFG_W      = 5;
	localparam int LINE_W      = $clog2(SCREEN_LINES);
	localparam int PLANE_W     = $clog2(PLANES);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [MASK_W-1:0] LAST_MASK    = MASK_W'(1) << (PLANES - 1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_PRINT = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_HOME  = 2'd2
	} action_e_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GLYPH_HEIGHT = 3'd0,
		CFG_ROW_COUNT    = 3'd1,
		CFG_WRAP_ROW     = 3'd2,
		CFG_START_COL    = 3'd3,
		CFG_START_ROW    = 3'd4
	} cfg_reg_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRAP,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic home;
		logic newline;
		logic start;
		logic wrap;
		logic issue;
	} dp_cmd_t;

	typedef struct packed {
		logic wrap_done;
		logic issue_last;
	} dp_status_t;

endpackage

### hw/rtl/tgpr_ifs.sv
// Handshake channels of the glyph renderer: command items, framebuffer writes, config.
interface tgpr_cmd_if;
	import tgpr_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CODE_W-1:0]   char_code;
	logic [COLOR_W-1:0]  color;
	logic [GLINE_W-1:0]  glyph_line;
	logic [CODE_W-1:0]   glyph_bits;
	modport source (output valid, action, char_code, color, glyph_line, glyph_bits,
		input ready);
	modport sink (input valid, action, char_code, color, glyph_line, glyph_bits,
		output ready);
endinterface

interface tgpr_fb_if;
	import tgpr_pkg::*;
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] plane_mask;
	logic [ADDR_W-1:0] byte_address;
	logic [7:0]        pixel_byte;
	logic              last;
	modport source (output valid, plane_mask, byte_address, pixel_byte, last, input ready);
	modport sink (input valid, plane_mask, byte_address, pixel_byte, last, output ready);
endinterface

interface tgpr_cfg_if;
	import tgpr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/text_glyph_planar_renderer_core.sv
// Top level of the planar text console glyph renderer.
// Load, home and newline items are taken while idle and emit nothing. A print item is taken
// while idle too, which also forms the text row's first pixel line; the walk then subtracts
// the screen height once per wrap step (never while the row lies on the screen, at most
// twice at the default sizes), loads the first line, and then emits 4 * glyph_height
// framebuffer bytes at one byte per cycle from the glyph store's single read port while the
// write channel does not stall; a write stall holds the walk. The next item is taken the
// cycle after the last byte's read is issued; the last two bytes drain through the read
// stage and output register behind it.
module text_glyph_planar_renderer_core #(
	parameter int MAX_GLYPH_HEIGHT = tgpr_pkg::MAX_GLYPH_HEIGHT_DEF,
	parameter int GLYPH_COUNT      = tgpr_pkg::GLYPH_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tgpr_cmd_if.sink   cmd,
	tgpr_cfg_if.sink   cfg,
	tgpr_fb_if.source  fb
);
	import tgpr_pkg::*;

	dp_cmd_t    cmd_c;
	dp_status_t stat;
	logic       in_ready;

	assign cmd.ready = in_ready;

	tgpr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cmd.valid),
		.in_action  (cmd.action),
		.in_newline (cmd.char_code == NEWLINE_CODE),
		.in_ready   (in_ready),
		.stat       (stat),
		.cmd_c      (cmd_c)
	);

	tgpr_datapath #(
		.MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
		.GLYPH_COUNT      (GLYPH_COUNT)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_c      (cmd_c),
		.stat       (stat),
		.char_code  (cmd.char_code),
		.color      (cmd.color),
		.glyph_line (cmd.glyph_line),
		.glyph_bits (cmd.glyph_bits),
		.cfg        (cfg),
		.fb         (fb)
	);
endmodule

### hw/rtl/tgpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tgpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

### hw/rtl/tgpr_ctrl.sv
// Sequencer of the glyph renderer: decodes items and steps the datapath.
module tgpr_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [tgpr_pkg::ACTION_W-1:0] in_action,
	input  logic                          in_newline,
	output logic                          in_ready,
	input  tgpr_pkg::dp_status_t          stat,
	output tgpr_pkg::dp_cmd_t             cmd_c
);
	import tgpr_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd_c    = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (action_e_t'(in_action))
						ACT_PRINT: begin
							if (in_newline) begin
								cmd_c.newline = 1'b1;
							end else begin
								cmd_c.start = 1'b1;
								state_d     = ST_WRAP;
							end
						end
						ACT_LOAD: cmd_c.load = 1'b1;
						ACT_HOME: cmd_c.home = 1'b1;
						default: ;
					endcase
				end
			end
			// reduce the first pixel line of the text row below the screen height
			ST_WRAP: begin
				cmd_c.wrap = 1'b1;
				if (stat.wrap_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd_c.issue = 1'b1;
				if (stat.issue_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### hw/rtl/tgpr_datapath.sv
// Glyph renderer datapath: config, cursor, glyph store, address walk, output register.
`include "text_glyph_planar_renderer_core_assert.svh"

module tgpr_datapath #(
	parameter int MAX_GLYPH_HEIGHT = tgpr_pkg::MAX_GLYPH_HEIGHT_DEF,
	parameter int GLYPH_COUNT      = tgpr_pkg::GLYPH_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tgpr_pkg::dp_cmd_t            cmd_c,
	output tgpr_pkg::dp_status_t         stat,
	input  logic [tgpr_pkg::CODE_W-1:0]  char_code,
	input  logic [tgpr_pkg::COLOR_W-1:0] color,
	input  logic [tgpr_pkg::GLINE_W-1:0] glyph_line,
	input  logic [tgpr_pkg::CODE_W-1:0]  glyph_bits,
	tgpr_cfg_if.sink                     cfg,
	tgpr_fb_if.source                    fb
);
	import tgpr_pkg::*;

	localparam int HW     = $clog2(MAX_GLYPH_HEIGHT + 1);
	localparam int IW     = (HW > 1) ? $clog2(MAX_GLYPH_HEIGHT) : 1;
	localparam int PROD_W = ROW_W + HW;
	localparam int BASE_W = (PROD_W > LINE_W + 1) ? PROD_W : LINE_W + 1;
	localparam int DEPTH  = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
	localparam int RAM_AW = $clog2(DEPTH);

	// configuration
	logic [HCFG_W-1:0] gh_q;
	logic [ROW_W-1:0]  rc_q, wrap_q, srow_q;
	logic [COL_W-1:0]  scol_q;
	// cursor
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	// current character
	logic [CODE_W-1:0]  code_q;
	logic [COLOR_W-1:0] color_q;
	logic               gvalid_q;
	logic [BASE_W-1:0]  base_q;
	logic [LINE_W-1:0]  line_q;
	logic [IW-1:0]      i_q;
	logic [PLANE_W-1:0] plane_q;
	// read stage
	logic               valid_s1;
	logic [PLANE_W-1:0] plane_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic               keep_s1;
	logic               last_s1;
	// output register
	logic              fb_valid_q;
	logic [MASK_W-1:0] mask_q;
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        byte_q;
	logic              last_q;

	logic [HW-1:0]     heff;
	logic [PROD_W-1:0] prod;
	logic [ROW_W-1:0]  row_next;
	logic [ADDR_W-1:0] addr_c;
	logic              advance, fire, last_step, line_end, wrap_ge, load_ok;
	logic [RAM_AW-1:0] wr_addr, rd_addr;
	logic [7:0]        rd_data;

	always_comb begin
		if (gh_q == '0) begin
			heff = HW'(1);
		end else if ({1'b0, gh_q} > (HCFG_W + 1)'(MAX_GLYPH_HEIGHT)) begin
			heff = HW'(MAX_GLYPH_HEIGHT);
		end else begin
			heff = HW'(gh_q);
		end
	end

	assign prod = PROD_W'(row_q) * PROD_W'(heff);

	always_comb begin
		if ((ROW_W + 1)'(row_q) + (ROW_W + 1)'(1) >= (ROW_W + 1)'(rc_q)) begin
			row_next = wrap_q;
		end else begin
			row_next = row_q + ROW_W'(1);
		end
	end

	assign advance   = !fb_valid_q || fb.ready;
	assign fire      = cmd_c.issue && advance;
	assign line_end  = (HW'(i_q) == heff - HW'(1));
	assign last_step = line_end && (plane_q == PLANE_W'(PLANES - 1));
	assign wrap_ge   = (base_q >= BASE_W'(SCREEN_LINES));
	assign addr_c    = ADDR_W'(line_q) * ADDR_W'(BYTES_PER_ROW) + ADDR_W'(col_q);

	assign stat.wrap_done  = !wrap_ge;
	assign stat.issue_last = fire && last_step;

	assign load_ok = ((CODE_W + 1)'(char_code) < (CODE_W + 1)'(GLYPH_COUNT)) &&
		((GLINE_W + 2)'(glyph_line) < (GLINE_W + 2)'(MAX_GLYPH_HEIGHT));
	assign wr_addr = RAM_AW'(char_code) * RAM_AW'(MAX_GLYPH_HEIGHT) + RAM_AW'(glyph_line);
	assign rd_addr = RAM_AW'(code_q) * RAM_AW'(MAX_GLYPH_HEIGHT) + RAM_AW'(i_q);

	tgpr_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_glyph_ram (
		.clk     (clk),
		.wr_en   (cmd_c.load && load_ok),
		.wr_addr (wr_addr),
		.wr_data (glyph_bits),
		.rd_en   (fire),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gh_q   <= HCFG_W'(16);
			rc_q   <= ROW_W'(30);
			wrap_q <= '0;
			scol_q <= '0;
			srow_q <= '0;
		end else if (cfg.valid) begin
			case (cfg_reg_e_t'(cfg.index))
				CFG_GLYPH_HEIGHT: gh_q   <= cfg.data[HCFG_W-1:0];
				CFG_ROW_COUNT:    rc_q   <= cfg.data[ROW_W-1:0];
				CFG_WRAP_ROW:     wrap_q <= cfg.data[ROW_W-1:0];
				CFG_START_COL:    scol_q <= cfg.data[COL_W-1:0];
				CFG_START_ROW:    srow_q <= cfg.data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd_c.home) begin
			col_q <= (scol_q < COL_W'(BYTES_PER_ROW)) ? scol_q : '0;
			row_q <= srow_q;
		end else if (cmd_c.newline) begin
			col_q <= '0;
			row_q <= row_next;
		end else if (fire && last_step) begin
			// addresses of this character are already in flight
			if (col_q + COL_W'(1) >= COL_W'(BYTES_PER_ROW)) begin
				col_q <= '0;
				row_q <= row_next;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// character walk: planes outer, glyph lines inner
	always_ff @(posedge clk) begin
		if (cmd_c.start) begin
			code_q   <= char_code;
			color_q  <= color;
			gvalid_q <= (CODE_W + 1)'(char_code) < (CODE_W + 1)'(GLYPH_COUNT);
			base_q   <= BASE_W'(prod);
		end else if (cmd_c.wrap) begin
			if (wrap_ge) begin
				base_q <= base_q - BASE_W'(SCREEN_LINES);
			end else begin
				line_q  <= LINE_W'(base_q);
				i_q     <= '0;
				plane_q <= '0;
			end
		end else if (fire) begin
			if (line_end) begin
				i_q     <= '0;
				line_q  <= LINE_W'(base_q);
				plane_q <= plane_q + PLANE_W'(1);
			end else begin
				i_q <= i_q + IW'(1);
				if (line_q == LINE_W'(SCREEN_LINES - 1)) begin
					line_q <= '0;
				end else begin
					line_q <= line_q + LINE_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			fb_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1   <= fire;
			fb_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			plane_s1 <= plane_q;
			addr_s1  <= addr_c;
			keep_s1  <= gvalid_q && color_q[plane_q];
			last_s1  <= last_step;
		end
		if (advance && valid_s1) begin
			mask_q <= MASK_W'(1) << plane_s1;
			addr_q <= addr_s1;
			byte_q <= keep_s1 ? rd_data : 8'h00;
			last_q <= last_s1;
		end
	end

	assign fb.valid        = fb_valid_q;
	assign fb.plane_mask   = mask_q;
	assign fb.byte_address = addr_q;
	assign fb.pixel_byte   = byte_q;
	assign fb.last         = last_q;

	`TGPR_ASSERT_IMPL(a_mask_onehot, clk, arst_n, fb_valid_q, $onehot(mask_q))
	`TGPR_ASSERT_IMPL(a_last_on_top_plane, clk, arst_n, fb_valid_q && last_q, mask_q == LAST_MASK)
	`TGPR_ASSERT_IMPL(a_addr_on_screen, clk, arst_n, fb_valid_q,
		addr_q < ADDR_W'(SCREEN_LINES * BYTES_PER_ROW))
	`TGPR_ASSERT_NEXT(a_last_issue_staged, clk, arst_n, stat.issue_last, valid_s1 && last_s1)

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the planar text glyph renderer: scoreboard, stimulus and checks.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tgpr_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 100;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [CODE_W-1:0]   char_code;
		logic [COLOR_W-1:0]  color;
		logic [GLINE_W-1:0]  glyph_line;
		logic [CODE_W-1:0]   glyph_bits;
	} cmd_item_t;

	typedef struct packed {
		logic [MASK_W-1:0] plane_mask;
		logic [ADDR_W-1:0] byte_address;
		logic [7:0]        pixel_byte;
		logic              last;
	} fb_write_t;

	// Tracks glyph rows, cursor and registers; predicts the framebuffer writes of each item.
	class glyph_scoreboard;
		bit [7:0]        glyph_rows [GLYPH_COUNT_DEF*MAX_GLYPH_HEIGHT_DEF];
		bit [HCFG_W-1:0] height_reg;
		bit [ROW_W-1:0]  rows_reg;
		bit [ROW_W-1:0]  wrap_reg;
		bit [COL_W-1:0]  home_col_reg;
		bit [ROW_W-1:0]  home_row_reg;
		int unsigned     cur_col;
		int unsigned     cur_row;
		fb_write_t       expected_writes [$];
		int              errors;
		int              writes_checked;
		int              chars_drawn;

		function new();
			height_reg = HCFG_W'(16);
			rows_reg = ROW_W'(30);
			wrap_reg = '0;
			home_col_reg = '0;
			home_row_reg = '0;
			cur_col = 0;
			cur_row = 0;
			errors = 0;
			writes_checked = 0;
			chars_drawn = 0;
		endfunction

		function void set_reg(cfg_reg_e_t idx, int unsigned val);
			case (idx)
				CFG_GLYPH_HEIGHT: height_reg = HCFG_W'(val);
				CFG_ROW_COUNT:    rows_reg = ROW_W'(val);
				CFG_WRAP_ROW:     wrap_reg = ROW_W'(val);
				CFG_START_COL:    home_col_reg = COL_W'(val);
				CFG_START_ROW:    home_row_reg = ROW_W'(val);
				default: ;
			endcase
		endfunction

		function int unsigned lines_per_glyph();
			if (height_reg == 0)
				return 1;
			if (height_reg > MAX_GLYPH_HEIGHT_DEF)
				return MAX_GLYPH_HEIGHT_DEF;
			return 32'(height_reg);
		endfunction

		function int pending();
			return expected_writes.size();
		endfunction

		// Reaching row_count always reloads wrap_row, whatever wrap_row holds.
		function void next_text_row();
			int unsigned r;
			r = cur_row + 1;
			if (r >= rows_reg)
				r = 32'(wrap_reg);
			cur_row = r % 64;
		endfunction

		function void note_cmd(cmd_item_t c);
			fb_write_t   w;
			int unsigned h;
			int unsigned line;
			case (c.action)
				ACT_LOAD: begin
					if (c.char_code < GLYPH_COUNT_DEF && c.glyph_line < MAX_GLYPH_HEIGHT_DEF)
						glyph_rows[int'(c.char_code)*MAX_GLYPH_HEIGHT_DEF + c.glyph_line] =
							c.glyph_bits;
				end
				ACT_HOME: begin
					cur_col = (home_col_reg < BYTES_PER_ROW) ? 32'(home_col_reg) : 0;
					cur_row = 32'(home_row_reg);
				end
				ACT_PRINT: begin
					if (c.char_code == NEWLINE_CODE) begin
						cur_col = 0;
						next_text_row();
					end else begin
						h = lines_per_glyph();
						chars_drawn++;
						for (int p = 0; p < PLANES; p++) begin
							for (int i = 0; i < h; i++) begin
								line = (cur_row * h + i) % SCREEN_LINES;
								w.plane_mask = MASK_W'(1 << p);
								w.byte_address = ADDR_W'(line * BYTES_PER_ROW + cur_col);
								w.pixel_byte = 8'h00;
								if (c.color[p] && c.char_code < GLYPH_COUNT_DEF)
									w.pixel_byte =
										glyph_rows[int'(c.char_code)*MAX_GLYPH_HEIGHT_DEF + i];
								w.last = (p == PLANES - 1) && (i == h - 1);
								expected_writes.push_back(w);
							end
						end
						cur_col++;
						if (cur_col >= BYTES_PER_ROW) begin
							cur_col = 0;
							next_text_row();
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void report(string field, logic [15:0] want, logic [15:0] got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: write %0d %s expected %h got %h", $time, writes_checked, field,
					want, got);
			else if (errors == MAX_REPORTS + 1)
				$display("%0t: further mismatches not shown", $time);
		endfunction

		function void check_write(fb_write_t got);
			fb_write_t want;
			if (expected_writes.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: write with none expected: mask %h addr %h byte %h last %b",
						$time, got.plane_mask, got.byte_address, got.pixel_byte, got.last);
				return;
			end
			want = expected_writes.pop_front();
			writes_checked++;
			if (got.plane_mask !== want.plane_mask)
				report("plane_mask", 16'(want.plane_mask), 16'(got.plane_mask));
			if (got.byte_address !== want.byte_address)
				report("byte_address", want.byte_address, got.byte_address);
			if (got.pixel_byte !== want.pixel_byte)
				report("pixel_byte", 16'(want.pixel_byte), 16'(got.pixel_byte));
			if (got.last !== want.last)
				report("last", 16'(want.last), 16'(got.last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	tgpr_cmd_if cmd_bus ();
	tgpr_cfg_if cfg_bus ();
	tgpr_fb_if  fb_bus ();

	text_glyph_planar_renderer_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.cfg    (cfg_bus),
		.fb     (fb_bus)
	);

	glyph_scoreboard sb;

	bit glyph_loaded [GLYPH_COUNT_DEF][MAX_GLYPH_HEIGHT_DEF];
	logic [CODE_W-1:0] used_codes [$];
	int items_sent = 0;
	int settings_used = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_acks = 0;
	int hold_left = 0;

	always #4 clk = ~clk;

	// Output back-pressure; a hold request forces a long stall so the block backs up.
	always @(negedge clk) begin
		if (hold_requests != hold_acks) begin
			hold_acks = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			fb_bus.ready <= 1'b0;
		end else begin
			fb_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		fb_write_t seen;
		if (arst_n === 1'b1 && fb_bus.valid === 1'b1 && fb_bus.ready === 1'b1) begin
			seen.plane_mask = fb_bus.plane_mask;
			seen.byte_address = fb_bus.byte_address;
			seen.pixel_byte = fb_bus.pixel_byte;
			seen.last = fb_bus.last;
			sb.check_write(seen);
		end
	end

	function automatic cmd_item_t make_item(logic [ACTION_W-1:0] action,
		logic [CODE_W-1:0] code, logic [COLOR_W-1:0] color, logic [GLINE_W-1:0] line,
		logic [CODE_W-1:0] bits);
		cmd_item_t it;
		it.action = action;
		it.char_code = code;
		it.color = color;
		it.glyph_line = line;
		it.glyph_bits = bits;
		return it;
	endfunction

	function automatic cmd_item_t random_fields();
		return make_item(ACTION_W'($urandom_range(3)), CODE_W'($urandom_range(255)),
			COLOR_W'($urandom_range(15)), GLINE_W'($urandom_range(15)),
			CODE_W'($urandom_range(255)));
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_item(cmd_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.action <= it.action;
		cmd_bus.char_code <= it.char_code;
		cmd_bus.color <= it.color;
		cmd_bus.glyph_line <= it.glyph_line;
		cmd_bus.glyph_bits <= it.glyph_bits;
		cmd_bus.valid <= 1'b1;
		do @(posedge clk); while (cmd_bus.ready !== 1'b1);
		sb.note_cmd(it);
		if (it.action == ACT_LOAD)
			glyph_loaded[it.char_code][it.glyph_line] = 1'b1;
		if (it.action != ACT_RESERVED)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic cfg_write(cfg_reg_e_t idx, int unsigned val);
		cfg_bus.index <= idx;
		cfg_bus.data <= CFG_DATA_W'(val);
		cfg_bus.valid <= 1'b1;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic apply_settings(int unsigned height, int unsigned rows, int unsigned wrap,
		int unsigned col, int unsigned row);
		cfg_write(CFG_GLYPH_HEIGHT, height);
		cfg_write(CFG_ROW_COUNT, rows);
		cfg_write(CFG_WRAP_ROW, wrap);
		cfg_write(CFG_START_COL, col);
		cfg_write(CFG_START_ROW, row);
		cfg_bus.valid <= 1'b0;
		settings_used++;
	endtask

	// Drops the command valid, then waits for every predicted write plus a short drain.
	task automatic wait_idle();
		cmd_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Loads any glyph row the current height will read, then prints.
	task automatic draw_char(logic [CODE_W-1:0] code, logic [COLOR_W-1:0] color);
		cmd_item_t   it;
		int unsigned h;
		h = sb.lines_per_glyph();
		if (code != NEWLINE_CODE) begin
			for (int i = 0; i < h; i++) begin
				if (!glyph_loaded[code][i])
					send_item(make_item(ACT_LOAD, code, color, GLINE_W'(i),
						CODE_W'($urandom_range(255))));
			end
		end
		it = random_fields();
		it.action = ACT_PRINT;
		it.char_code = code;
		it.color = color;
		send_item(it);
	endtask

	task automatic random_step();
		cmd_item_t         it;
		int unsigned       pick;
		logic [CODE_W-1:0] code;
		pick = $urandom_range(99);
		it = random_fields();
		if (pick < 10) begin
			it.action = ACT_LOAD;
			send_item(it);
		end else if (pick < 16) begin
			it.action = ACT_HOME;
			send_item(it);
		end else if (pick < 20) begin
			it.action = ACT_RESERVED;
			send_item(it);
		end else if (pick < 28) begin
			it.action = ACT_PRINT;
			it.char_code = NEWLINE_CODE;
			send_item(it);
		end else begin
			if (used_codes.size() != 0 && $urandom_range(3) != 0) begin
				code = used_codes[$urandom_range(used_codes.size() - 1)];
			end else begin
				code = CODE_W'($urandom_range(255));
				used_codes.push_back(code);
			end
			draw_char(code, COLOR_W'($urandom_range(15)));
		end
	endtask

	task automatic run_phase(int unsigned height, int unsigned rows, int unsigned wrap,
		int unsigned col, int unsigned row, int sidle, int rstall, int n_items, bit with_hold);
		int target;
		cmd_item_t it;
		wait_idle();
		apply_settings(height, rows, wrap, col, row);
		send_idle_pct = sidle;
		recv_stall_pct = rstall;
		if (with_hold)
			hold_requests <= hold_requests + 1;
		target = items_sent + n_items;
		it = random_fields();
		it.action = ACT_HOME;
		send_item(it);
		while (items_sent < target)
			random_step();
	endtask

	task automatic directed_items();
		wait_idle();
		apply_settings(2, 30, 0, 0, 0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_item(make_item(ACT_LOAD, 8'h00, 4'h0, 4'd0, 8'hFF));
		send_item(make_item(ACT_LOAD, 8'h00, 4'h0, 4'd1, 8'h00));
		send_item(make_item(ACT_LOAD, 8'hFF, 4'hF, 4'd0, 8'h80));
		send_item(make_item(ACT_LOAD, 8'hFF, 4'hF, 4'd1, 8'h01));
		send_item(make_item(ACT_LOAD, 8'hFF, 4'h0, 4'd15, 8'hAA));
		// color zero: all planes written blank
		send_item(make_item(ACT_PRINT, 8'h00, 4'h0, 4'd0, 8'h00));
		send_item(make_item(ACT_PRINT, 8'hFF, 4'hF, 4'd15, 8'hFF));
		send_item(make_item(ACT_PRINT, 8'h00, 4'h5, 4'd0, 8'h00));
		send_item(make_item(ACT_PRINT, NEWLINE_CODE, 4'hF, 4'd0, 8'h00));
		send_item(make_item(ACT_RESERVED, 8'hFF, 4'hF, 4'd15, 8'hFF));
		send_item(make_item(ACT_PRINT, 8'hFF, 4'hA, 4'd0, 8'h00));
		send_item(make_item(ACT_HOME, 8'h00, 4'h0, 4'd0, 8'h00));
		send_item(make_item(ACT_PRINT, 8'hFF, 4'h8, 4'd0, 8'h00));
		send_item(make_item(ACT_PRINT, 8'h00, 4'h1, 4'd0, 8'h00));
		used_codes.push_back(8'h00);
		used_codes.push_back(8'hFF);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.action = ACT_PRINT;
		cmd_bus.char_code = '0;
		cmd_bus.color = '0;
		cmd_bus.glyph_line = '0;
		cmd_bus.glyph_bits = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = CFG_GLYPH_HEIGHT;
		cfg_bus.data = '0;
		fb_bus.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_items();
		run_phase(16, 30, 0, 0, 0, 0, 0, 30, 1'b0);
		run_phase(1, 1, 0, 79, 59, 50, 0, 30, 1'b0);
		// zero height, start column past the screen, wrap row not below row count
		run_phase(0, 63, 63, 127, 63, 0, 50, 30, 1'b0);
		run_phase(31, 0, 5, 80, 1, 18, 18, 30, 1'b0);
		// tall rows far down the screen push pixel lines past the bottom
		run_phase(16, 60, 59, 78, 58, 0, 0, 25, 1'b1);
		run_phase($urandom_range(1, 16), $urandom_range(1, 60), $urandom_range(59),
			$urandom_range(79), $urandom_range(59), 18, 18, 30, 1'b0);
		wait_idle();

		$display("Covered %0d command items, %0d characters drawn, over %0d register settings.",
			items_sent, sb.chars_drawn, settings_used);
		$display("Checked %0d framebuffer writes with input gaps, output stalls and a %0d-cycle hold.",
			sb.writes_checked, HOLD_CYCLES);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/tgpr_pkg.sv
hw/rtl/tgpr_ifs.sv
hw/rtl/tgpr_ram.sv
hw/rtl/tgpr_ctrl.sv
hw/rtl/tgpr_datapath.sv
hw/rtl/text_glyph_planar_renderer_core.sv
tb/sv/tb_top.sv
